@@ rtl/ycr_pkg.sv @@
// Shared types, constants and helpers for the YCbCr to RGB converter.
`timescale 1ns / 1ps

package ycr_pkg;

  // Component and sum widths
  localparam int COMP_W = 8;
  localparam int SUM_W  = 20;

  // Entries in the queue between the front and back parts
  localparam int QUEUE_DEPTH = 4;

  // Register map (byte addresses, one 32-bit register)
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic [APB_ADDR_W-1:0] REG_PIXEL_FORMAT = 3'd0;

  // Pixel format codes
  localparam logic FMT_PACKED_422 = 1'b0;
  localparam logic FMT_SEMI_420   = 1'b1;

  // Pixel index of the final pixel in each format
  localparam logic [1:0] LAST_PIX_422 = 2'd1;
  localparam logic [1:0] LAST_PIX_420 = 2'd3;

  // Alpha per format
  localparam logic [COMP_W-1:0] ALPHA_422 = 8'd255;
  localparam logic [COMP_W-1:0] ALPHA_420 = 8'd0;

  // Offsets and coefficients of the integer formula
  localparam logic signed [SUM_W-1:0] LUMA_OFFSET   = 20'sd16;
  localparam logic signed [SUM_W-1:0] CHROMA_OFFSET = 20'sd128;
  localparam logic signed [SUM_W-1:0] ROUND_BIAS    = 20'sd128;
  localparam logic signed [SUM_W-1:0] K_LUMA        = 20'sd298;
  localparam logic signed [SUM_W-1:0] K_CR_RED      = 20'sd409;
  localparam logic signed [SUM_W-1:0] K_CB_GREEN    = 20'sd100;
  localparam logic signed [SUM_W-1:0] K_CR_GREEN    = 20'sd208;
  localparam logic signed [SUM_W-1:0] K_CB_BLUE     = 20'sd516;
  localparam logic [COMP_W-1:0]       COMP_MAX      = 8'd255;

  // Bit positions in the output tuser
  localparam int USER_LINE = 0;
  localparam int USER_COL  = 1;

  // One queued group: four lumas, chroma contributions, format
  typedef struct packed {
    logic [3:0][COMP_W-1:0]   luma;
    logic signed [SUM_W-1:0]  red_chroma;
    logic signed [SUM_W-1:0]  green_chroma;
    logic signed [SUM_W-1:0]  blue_chroma;
    logic                     fmt;
  } group_t;

  // Queue status seen by the front and back parts
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  // Floor-shift by 8 and clip to 0..255
  function automatic logic [COMP_W-1:0] clip8(input logic signed [SUM_W-1:0] sum);
    logic [COMP_W-1:0] res;
    if (sum[SUM_W-1]) begin
      res = '0;
    end else if (|sum[SUM_W-2:2*COMP_W]) begin
      res = COMP_MAX;
    end else begin
      res = sum[2*COMP_W-1:COMP_W];
    end
    return res;
  endfunction

endpackage

@@ rtl/ycr_front.sv @@
// Front part: accept input groups, work out chroma terms, push into the queue.
`timescale 1ns / 1ps

module ycr_front (
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [47:0]           s_tdata,
  input  logic                  pixel_format,
  input  ycr_pkg::queue_status_t q_status,
  output logic                  push,
  output ycr_pkg::group_t       push_group
);

  logic signed [ycr_pkg::SUM_W-1:0] d;
  logic signed [ycr_pkg::SUM_W-1:0] e;

  assign s_tready = !q_status.full;
  assign push     = s_tvalid && s_tready;

  always_comb begin
    d = $signed({{(ycr_pkg::SUM_W-ycr_pkg::COMP_W){1'b0}}, s_tdata[39:32]})
        - ycr_pkg::CHROMA_OFFSET;
    e = $signed({{(ycr_pkg::SUM_W-ycr_pkg::COMP_W){1'b0}}, s_tdata[47:40]})
        - ycr_pkg::CHROMA_OFFSET;
    push_group.luma[0]      = s_tdata[7:0];
    push_group.luma[1]      = s_tdata[15:8];
    push_group.luma[2]      = s_tdata[23:16];
    push_group.luma[3]      = s_tdata[31:24];
    push_group.red_chroma   = e * ycr_pkg::K_CR_RED;
    push_group.green_chroma = -(d * ycr_pkg::K_CB_GREEN) - (e * ycr_pkg::K_CR_GREEN);
    push_group.blue_chroma  = d * ycr_pkg::K_CB_BLUE;
    // Latch the format with the group so each one converts as it arrived
    push_group.fmt          = pixel_format;
  end

endmodule

@@ rtl/ycr_queue.sv @@
// Short queue of classified groups between the front and back parts.
`timescale 1ns / 1ps

module ycr_queue #(
  parameter int DEPTH = ycr_pkg::QUEUE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  ycr_pkg::group_t        push_group,
  input  logic                   pop,
  output ycr_pkg::group_t        head,
  output ycr_pkg::queue_status_t status
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  ycr_pkg::group_t mem [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  assign status.full  = (count == CW'(DEPTH));
  assign status.empty = (count == '0);
  assign head         = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_group;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

@@ rtl/ycr_back.sv @@
// Back part: walk the pixels of the head group and drive the output register.
`timescale 1ns / 1ps

module ycr_back (
  input  logic                   clk,
  input  logic                   rst,
  input  ycr_pkg::group_t        head,
  input  ycr_pkg::queue_status_t q_status,
  output logic                   pop,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [31:0]            m_tdata,
  output logic [1:0]             m_tuser,
  output logic                   m_tlast
);

  logic [1:0]                       pix_idx;
  logic [1:0]                       last_idx;
  logic                             load;
  logic                             is_last;
  logic signed [ycr_pkg::SUM_W-1:0] c;
  logic signed [ycr_pkg::SUM_W-1:0] luma_term;
  logic signed [ycr_pkg::SUM_W-1:0] red_sum;
  logic signed [ycr_pkg::SUM_W-1:0] green_sum;
  logic signed [ycr_pkg::SUM_W-1:0] blue_sum;

  assign last_idx = (head.fmt == ycr_pkg::FMT_SEMI_420) ? ycr_pkg::LAST_PIX_420
                                                         : ycr_pkg::LAST_PIX_422;
  assign is_last  = (pix_idx == last_idx);
  // Advance when a group is queued and the output register is free or being drained
  assign load     = !q_status.empty && (!m_tvalid || m_tready);
  assign pop      = load && is_last;

  always_comb begin
    c = $signed({{(ycr_pkg::SUM_W-ycr_pkg::COMP_W){1'b0}}, head.luma[pix_idx]})
        - ycr_pkg::LUMA_OFFSET;
    luma_term = c * ycr_pkg::K_LUMA;
    red_sum   = luma_term + head.red_chroma   + ycr_pkg::ROUND_BIAS;
    green_sum = luma_term + head.green_chroma + ycr_pkg::ROUND_BIAS;
    blue_sum  = luma_term + head.blue_chroma  + ycr_pkg::ROUND_BIAS;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      pix_idx  <= '0;
    end else begin
      if (load) begin
        m_tvalid <= 1'b1;
        pix_idx  <= is_last ? 2'd0 : pix_idx + 2'd1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata[7:0]   <= ycr_pkg::clip8(red_sum);
      m_tdata[15:8]  <= ycr_pkg::clip8(green_sum);
      m_tdata[23:16] <= ycr_pkg::clip8(blue_sum);
      m_tdata[31:24] <= (head.fmt == ycr_pkg::FMT_SEMI_420) ? ycr_pkg::ALPHA_420
                                                           : ycr_pkg::ALPHA_422;
      m_tuser[ycr_pkg::USER_LINE] <= pix_idx[1];
      m_tuser[ycr_pkg::USER_COL]  <= pix_idx[0];
      m_tlast <= is_last;
    end
  end

endmodule

@@ rtl/ycbcr_to_rgb_pixel_converter.sv @@
// Top level: BT.601 video-range YCbCr group to RGB pixel converter.
// Groups queue, then the single-pixel output register sets the output rate.
// Throughput: one pixel per cycle on the output while a group is queued and m_tready
//   is high; a 4:2:2 group gives 2 pixels and a 4:2:0 group gives 4.
// Input groups are taken every cycle while the queue has room.
// Reset (rst, synchronous): empties the queue and output, pixel_format returns to 0.
`timescale 1ns / 1ps

module ycbcr_to_rgb_pixel_converter #(
  parameter int QUEUE_DEPTH = ycr_pkg::QUEUE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst,
  // Input group stream
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // [7:0] luma_top_left, [15:8] luma_top_right, [23:16] luma_bottom_left,
  // [31:24] luma_bottom_right, [39:32] chroma_blue, [47:40] chroma_red
  input  logic [47:0]                    s_tdata,
  // Output pixel stream
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha
  output logic [31:0]                    m_tdata,
  // [0] line_select, [1] column_select
  output logic [1:0]                     m_tuser,
  output logic                           m_tlast,
  // Configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ycr_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [ycr_pkg::APB_DATA_W-1:0] pwdata,
  output logic [ycr_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);

  logic                   pixel_format;
  logic                   reg_hit;
  logic                   push;
  logic                   pop;
  ycr_pkg::group_t        push_group;
  ycr_pkg::group_t        head;
  ycr_pkg::queue_status_t q_status;

  // Register decode ignores the byte offset within the word
  assign pready  = 1'b1;
  assign reg_hit = (paddr[ycr_pkg::APB_ADDR_W-1:2] ==
                    ycr_pkg::REG_PIXEL_FORMAT[ycr_pkg::APB_ADDR_W-1:2]);
  assign prdata  = reg_hit ? {{(ycr_pkg::APB_DATA_W-1){1'b0}}, pixel_format} : '0;

  // Keep only bit 0 of a write to the format register; other addresses drop the write
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_format <= ycr_pkg::FMT_PACKED_422;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      pixel_format <= pwdata[0];
    end
  end

  // Front: take a group while the queue has room, tag it with the format
  ycr_front u_front (
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .pixel_format (pixel_format),
    .q_status     (q_status),
    .push         (push),
    .push_group   (push_group)
  );

  // Queue decouples the input handshake from the pixel walk
  ycr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_group (push_group),
    .pop        (pop),
    .head       (head),
    .status     (q_status)
  );

  // Back: emit one pixel per transaction, pop the group as its final pixel is loaded
  ycr_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .q_status (q_status),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // Never write into a full queue
  assert property (@(posedge clk) disable iff (rst) push |-> !q_status.full)
    else $error("push into full queue");

  // Never pop an empty queue
  assert property (@(posedge clk) disable iff (rst) pop |-> !q_status.empty)
    else $error("pop from empty queue");

  // Final pixel is always the right column, on the lower line only for 4:2:0
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> (m_tuser[ycr_pkg::USER_COL] &&
      (m_tuser[ycr_pkg::USER_LINE] == (m_tdata[31:24] == ycr_pkg::ALPHA_420))))
    else $error("final pixel position disagrees with format");

  // A popped group leaves the output holding its final pixel
  assert property (@(posedge clk) disable iff (rst) pop |=> (m_tvalid && m_tlast))
    else $error("group popped without final pixel");

endmodule
